@@ rtl/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned ValueW            = 32;
  localparam int unsigned CountOutW         = 5;

  // request codes
  typedef enum logic {
    REQ_ENQUEUE = 1'b0,
    REQ_DEQUEUE = 1'b1
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_cmd_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// sorted priority queue top level: cell chain, entry count and result register
// result: the result of an accepted request is registered at the clock edge that accepts it
// throughput: one request per cycle when not stalled; every cell compares against the new value
// in parallel and moves by one place, so the rate is set by the single compare in each cell
// reset clears the entry count and the result valid flag; cell contents stay unknown
// until written, and only occupied cells are ever read
module sorted_priority_queue #(
  parameter int unsigned QueueDepth = spq_pkg::QueueDepthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic signed [spq_pkg::ValueW-1:0]   value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic signed [spq_pkg::ValueW-1:0]   removed_value,
  output logic [spq_pkg::CountOutW-1:0]       entry_count,
  output logic                                is_empty,
  output logic                                is_full
);
  import spq_pkg::*;

  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  // number of held entries
  logic [CountW-1:0]        count;
  logic [CountW-1:0]        count_next;

  // chain signals
  logic signed [ValueW-1:0] cell_value [QueueDepth];
  logic [QueueDepth-1:0]    cell_ge;
  logic [QueueDepth-1:0]    cell_occupied;

  logic                     accept;
  logic                     full_now;
  logic                     empty_now;
  cell_cmd_t                cmd;
  status_t                  status_next;
  logic signed [ValueW-1:0] removed_next;

  // the result register frees up in the same cycle its transfer completes
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full_now  = (count == CountW'(QueueDepth));
  assign empty_now = (count == '0);

  // decode the request into a chain command; rejected requests leave the chain alone
  always_comb begin
    cmd          = '0;
    status_next  = STATUS_OK;
    removed_next = '0;
    count_next   = count;
    unique case (req_t'(req_type))
      REQ_ENQUEUE: begin
        if (full_now) begin
          status_next = STATUS_FULL;
        end else begin
          cmd.insert = accept;
          count_next = count + 1'b1;
        end
      end
      REQ_DEQUEUE: begin
        if (empty_now) begin
          status_next = STATUS_EMPTY;
        end else begin
          cmd.remove   = accept;
          removed_next = cell_value[0];
          count_next   = count - 1'b1;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  // the cell chain: cell 0 holds the largest entry
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic                     left_ge;
    logic signed [ValueW-1:0] left_value;
    logic signed [ValueW-1:0] right_value;

    assign cell_occupied[i] = (count > CountW'(i));

    if (i == 0) begin : g_head
      // nothing sits left of the head, so a new value lands here unless it is beaten
      assign left_ge    = 1'b1;
      assign left_value = value;
    end else begin : g_body
      assign left_ge    = cell_ge[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      // tail keeps its own entry on a removal; it is unoccupied afterward anyway
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (cell_occupied[i]),
      .new_value   (value),
      .left_ge     (left_ge),
      .left_value  (left_value),
      .right_value (right_value),
      .ge          (cell_ge[i]),
      .value       (cell_value[i])
    );
  end

  // entry count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only on an accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_value <= removed_next;
      entry_count   <= CountOutW'(count_next);
      is_empty      <= (count_next == '0);
      is_full       <= (count_next == CountW'(QueueDepth));
    end
  end

endmodule

@@ rtl/spq_cell.sv @@
// one storage cell of the sorted chain: holds one entry and talks to its neighbors
module spq_cell (
  input  logic                           clk,
  input  spq_pkg::cell_cmd_t             cmd,
  input  logic                           occupied,
  input  logic signed [spq_pkg::ValueW-1:0] new_value,
  input  logic                           left_ge,
  input  logic signed [spq_pkg::ValueW-1:0] left_value,
  input  logic signed [spq_pkg::ValueW-1:0] right_value,
  output logic                           ge,
  output logic signed [spq_pkg::ValueW-1:0] value
);
  import spq_pkg::*;

  logic signed [ValueW-1:0] value_next;

  // held entry is at least the new value; true over a prefix of the chain
  assign ge = occupied && (value >= new_value);

  always_comb begin
    value_next = value;
    priority if (cmd.insert) begin
      if (ge) begin
        value_next = value;
      end else if (left_ge) begin
        value_next = new_value;
      end else begin
        value_next = left_value;
      end
    end else if (cmd.remove) begin
      value_next = right_value;
    end else begin
      // no command this cycle: hold
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ bench/sorted_priority_queue_check.sv @@
// result checker for the sorted priority queue: watches both channels and compares results
module sorted_priority_queue_check #(
  parameter int unsigned Depth = spq_pkg::QueueDepthDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               req_type,
  input  logic signed [spq_pkg::ValueW-1:0]  value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [1:0]                         status,
  input  logic signed [spq_pkg::ValueW-1:0]  removed_value,
  input  logic [spq_pkg::CountOutW-1:0]      entry_count,
  input  logic                               is_empty,
  input  logic                               is_full,
  output int                                 fail_count,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  typedef struct packed {
    status_t                     status;
    logic signed [ValueW-1:0]    removed;
    logic [CountOutW-1:0]        count;
    logic                        empty;
    logic                        full;
  } queue_result_t;

  // shadow of the queue contents, largest first
  logic signed [ValueW-1:0] model_entries [Depth];
  int unsigned              model_total;
  queue_result_t            pending_results [$];

  function automatic queue_result_t apply_request(req_t kind, logic signed [ValueW-1:0] val);
    queue_result_t res;
    int unsigned   pos;
    res = '0;
    res.status = STATUS_OK;
    if (kind == REQ_ENQUEUE) begin
      if (model_total >= Depth) begin
        res.status = STATUS_FULL;
      end else begin
        // equal values keep arrival order
        pos = 0;
        while (pos < model_total && model_entries[pos] >= val) pos++;
        for (int unsigned i = model_total; i > pos; i--) model_entries[i] = model_entries[i-1];
        model_entries[pos] = val;
        model_total++;
      end
    end else begin
      if (model_total == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.removed = model_entries[0];
        for (int unsigned i = 1; i < model_total; i++) model_entries[i-1] = model_entries[i];
        model_total--;
      end
    end
    res.count = CountOutW'(model_total);
    res.empty = (model_total == 0);
    res.full  = (model_total >= Depth);
    return res;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      model_total = 0;
      pending_results.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_request(req_t'(req_type), value));
      end
      if (out_valid && !out_stall) begin
        got = '{status_t'(status), removed_value, entry_count, is_empty, is_full};
        if (pending_results.size() == 0) begin
          $error("result transfer with no request waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.removed !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed, got.removed);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
          if (got.empty !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
            fail_count++;
          end
          if (got.full !== want.full) begin
            $error("is_full: expected %0d, got %0d", want.full, got.full);
            fail_count++;
          end
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

@@ bench/sorted_priority_queue_test.sv @@
// top of the sorted priority queue bench: clock, reset, request stimulus and verdict
module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int unsigned Depth      = QueueDepthDefault;
  localparam int          ItemTarget = 1650;
  // quiet tail: the last requests go out with no gaps and no stalls
  localparam int          TailItems  = 200;
  // cycles without any transfer before the run is declared hung
  localparam int          QuietLimit = 1000;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     req_type;
  logic signed [ValueW-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic signed [ValueW-1:0] removed_value;
  logic [CountOutW-1:0]     entry_count;
  logic                     is_empty;
  logic                     is_full;

  int fail_count;
  int outstanding;
  int sent_count  = 0;
  int quiet_cycles = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b0;

  sorted_priority_queue #(.QueueDepth(Depth)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .is_full       (is_full)
  );

  sorted_priority_queue_check #(.Depth(Depth)) u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .is_full       (is_full),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always #5 clk = ~clk;

  // result side back-pressure: random stall bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && !rst && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(1, 11);
      end
    end
  end

  // hang detector: any transfer on either channel clears the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // values: extremes, a narrow band around zero for ties, sign-boundary neighbors, full random
  function automatic logic signed [ValueW-1:0] pick_value();
    logic signed [ValueW-1:0] val;
    case ($urandom_range(0, 9))
      0:       val = 32'sh8000_0000;
      1:       val = 32'sh7fff_ffff;
      2:       val = '0;
      3:       val = -1;
      4, 5:    val = $urandom_range(0, 6) - 3;
      6:       val = $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                          : 32'sh8000_0000 + $urandom_range(0, 3);
      default: val = $urandom();
    endcase
    return val;
  endfunction

  // one request transfer; entered and left at a falling edge, valid stays high
  // across back-to-back transfers unless a gap is drawn
  task automatic send_request(input req_t kind, input logic signed [ValueW-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    value    <= val;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    sent_count++;
  endtask

  initial begin
    int   mode;
    int   run_len;
    int   enq_pct;
    req_t kind;
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    req_type  = REQ_ENQUEUE;
    value     = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: dequeue from empty, extremes and ties, then drain past empty
    send_request(REQ_DEQUEUE, 32'sh1234_5678);
    send_request(REQ_ENQUEUE, 32'sh8000_0000);
    send_request(REQ_ENQUEUE, 32'sh7fff_ffff);
    send_request(REQ_ENQUEUE, '0);
    send_request(REQ_ENQUEUE, -1);
    send_request(REQ_ENQUEUE, 1);
    send_request(REQ_ENQUEUE, -1);
    send_request(REQ_ENQUEUE, 32'sh7fff_ffff);
    send_request(REQ_ENQUEUE, 32'sh8000_0000);
    repeat (9) send_request(REQ_DEQUEUE, $urandom());

    // random phases: fill runs push into the full-reject path, drain runs into the
    // empty-reject path, mixed runs churn the middle of the ordering
    while (sent_count < ItemTarget) begin
      idle_on = (sent_count < ItemTarget - TailItems) && ($urandom_range(0, 9) < 7);
      mode    = $urandom_range(0, 3);
      case (mode)
        0:       enq_pct = 90;
        1:       enq_pct = 10;
        2:       enq_pct = 50;
        default: enq_pct = 65;
      endcase
      run_len = (mode < 2) ? $urandom_range(16, 26) : $urandom_range(8, 40);
      repeat (run_len) begin
        kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
        send_request(kind, pick_value());
      end
    end
    idle_on = 1'b0;
    in_valid <= 1'b0;

    // let every expected result arrive, then keep watching for strays before the verdict
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
